>>> hw/rtl/gmt_pkg.sv
// ============================================================================
// gmt_pkg
// Shared types and constants for the group membership table.
// ============================================================================
package gmt_pkg;

    // Field widths
    localparam int GID_W      = 8;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 3;
    localparam int CNT_W      = 7;
    localparam int IN_TDATA_W = 16;
    localparam int OUT_TDATA_W = 16;

    // Reserved marker held by an empty slot
    localparam logic [GID_W-1:0] EMPTY_MARK = 8'hFF;

    // Operation codes; unlisted codes behave as a query
    typedef enum logic [OP_W-1:0] {
        OP_QUERY     = 3'd0,
        OP_ADD       = 3'd1,
        OP_REMOVE    = 3'd2,
        OP_CLEAR     = 3'd3,
        OP_CLEAR_ADD = 3'd4
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_INVALID   = 3'd5
    } status_t;

    // Summary flags from the slot lookup
    typedef struct packed {
        logic hit;       // id found in some slot
        logic has_free;  // at least one slot holds the empty marker
    } lkp_flags_t;

endpackage

>>> hw/rtl/gmt_lookup.sv
// ============================================================================
// gmt_lookup
// Parallel compare of one group id against every slot, with lowest-match
// and lowest-free one-hot selection.
// ============================================================================
module gmt_lookup
    import gmt_pkg::*;
#(
    parameter int SLOT_COUNT = 8
)
(
    input  logic [SLOT_COUNT-1:0][GID_W-1:0] slots,
    input  logic [GID_W-1:0]                 id,
    output logic [SLOT_COUNT-1:0]            match_oh,
    output logic [SLOT_COUNT-1:0]            free_oh,
    output lkp_flags_t                       flags
);

    logic [SLOT_COUNT-1:0] match_vec;
    logic [SLOT_COUNT-1:0] free_vec;
    logic                  id_ok;

    // Per-slot compares; the empty marker never matches
    assign id_ok = (id != EMPTY_MARK);

    always_comb
    begin
        for (int k = 0; k < SLOT_COUNT; k++)
        begin
            match_vec[k] = id_ok && (slots[k] == id);
            free_vec[k]  = (slots[k] == EMPTY_MARK);
        end
    end

    // Keep only the lowest set bit of each vector
    assign match_oh = match_vec & (~match_vec + 1'b1);
    assign free_oh  = free_vec & (~free_vec + 1'b1);

    assign flags.hit      = |match_vec;
    assign flags.has_free = |free_vec;

endmodule

>>> hw/rtl/group_membership_table.sv
// A result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one word per cycle; the slot compare and first-free encoder
// finish within the cycle, and the output register lets input proceed while
// a result waits, as long as the downstream side takes one word per cycle.
// Reset: asynchronous, active low; every slot holds the empty marker, count 0.
// ============================================================================
// group_membership_table
// Small associative set of group ids with first-free-slot insertion,
// query, remove and clear, one result word per input word.
// ============================================================================
module group_membership_table
    import gmt_pkg::*;
#(
    parameter int SLOT_COUNT = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // [2:0] operation, [10:3] group_id, [15:11] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic                   s_axis_tlast,   // message_end
    // [0] is_member, [3:1] status, [10:4] group_count, [15:11] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic                   m_axis_tlast    // message_done
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOT_COUNT);

    // Table state
    logic [SLOT_COUNT-1:0][GID_W-1:0] slots_reg, slots_next;
    logic [CNT_W-1:0]                 count_reg, count_next;

    // Output register
    logic                out_valid_reg;
    logic                out_member_reg, member_next;
    status_t             out_status_reg, status_next;
    logic [CNT_W-1:0]    out_count_reg;
    logic                out_last_reg;

    logic [OP_W-1:0]       op_bits;
    logic [GID_W-1:0]      id;
    logic                  id_ok;
    logic                  full;
    logic                  accept;
    logic [SLOT_COUNT-1:0] match_oh;
    logic [SLOT_COUNT-1:0] free_oh;
    lkp_flags_t            flags;

    // Input unpack and handshake
    assign op_bits       = s_axis_tdata[OP_W-1:0];
    assign id            = s_axis_tdata[OP_W +: GID_W];
    assign id_ok         = (id != EMPTY_MARK);
    assign full          = (count_reg >= FULL_CNT);
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    gmt_lookup #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_lookup (
        .slots    (slots_reg),
        .id       (id),
        .match_oh (match_oh),
        .free_oh  (free_oh),
        .flags    (flags)
    );

    // Operation decode and next table state
    always_comb
    begin
        slots_next  = slots_reg;
        count_next  = count_reg;
        status_next = ST_DONE;
        member_next = 1'b0;
        case (op_t'(op_bits))
            OP_ADD:
            begin
                if (!id_ok)
                    status_next = ST_INVALID;
                else if (full)
                begin
                    status_next = ST_FULL;
                    member_next = flags.hit;
                end
                else if (flags.hit)
                begin
                    status_next = ST_PRESENT;
                    member_next = 1'b1;
                end
                else if (!flags.has_free)
                    status_next = ST_FULL;
                else
                begin
                    for (int k = 0; k < SLOT_COUNT; k++)
                        if (free_oh[k])
                            slots_next[k] = id;
                    count_next  = count_reg + 1'b1;
                    member_next = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (!id_ok)
                    status_next = ST_INVALID;
                else if (count_reg == '0)
                    status_next = ST_EMPTY;
                else if (!flags.hit)
                    status_next = ST_NOT_FOUND;
                else
                begin
                    for (int k = 0; k < SLOT_COUNT; k++)
                        if (match_oh[k])
                            slots_next[k] = EMPTY_MARK;
                    count_next = count_reg - 1'b1;
                end
            end
            OP_CLEAR:
            begin
                for (int k = 0; k < SLOT_COUNT; k++)
                    slots_next[k] = EMPTY_MARK;
                count_next = '0;
            end
            OP_CLEAR_ADD:
            begin
                // After the clear, the new id lands in the lowest slot
                for (int k = 0; k < SLOT_COUNT; k++)
                    slots_next[k] = EMPTY_MARK;
                if (id_ok)
                begin
                    slots_next[0] = id;
                    count_next    = CNT_W'(1);
                    member_next   = 1'b1;
                end
                else
                begin
                    count_next  = '0;
                    status_next = ST_INVALID;
                end
            end
            default:
            begin
                // Query, also taken by the unused codes
                if (!id_ok)
                    status_next = ST_INVALID;
                else
                begin
                    status_next = flags.hit ? ST_DONE : ST_NOT_FOUND;
                    member_next = flags.hit;
                end
            end
        endcase
    end

    // Table state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SLOT_COUNT; k++)
                slots_reg[k] <= EMPTY_MARK;
            count_reg <= '0;
        end
        else if (accept)
        begin
            slots_reg <= slots_next;
            count_reg <= count_next;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_member_reg <= member_next;
            out_status_reg <= status_next;
            out_count_reg  <= count_next;
            out_last_reg   <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - 1 - STATUS_W - CNT_W)'(0),
                            out_count_reg, out_status_reg, out_member_reg};

endmodule

>>> hw/rtl/gmt_checker.sv
// ============================================================================
// gmt_checker
// Port-level checks for the group membership table, bound to the top level.
// ============================================================================
module gmt_checker
    import gmt_pkg::*;
#(
    parameter int SLOT_COUNT = 8
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   s_axis_tlast,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic                   m_axis_tlast
);

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOT_COUNT);

    logic             s_acc;
    logic             m_member;
    logic [STATUS_W-1:0] m_status;
    logic [CNT_W-1:0] m_count;
    logic [GID_W-1:0] s_id;

    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign m_member = m_axis_tdata[0];
    assign m_status = m_axis_tdata[STATUS_W:1];
    assign m_count  = m_axis_tdata[STATUS_W+1 +: CNT_W];
    assign s_id     = s_axis_tdata[OP_W +: GID_W];

    // A pending result word holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word dropped or changed while stalled");

    // Each accepted word yields a result next cycle carrying its end mark
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |=> m_axis_tvalid && (m_axis_tlast == $past(s_axis_tlast)))
        else $error("accepted word produced no matching result");

    // Count never exceeds the table size
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_count <= FULL_CNT)
        else $error("group count above slot count");

    // The empty marker is never reported as a member
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && (s_id == EMPTY_MARK) |=> !m_member && m_status != ST_PRESENT)
        else $error("empty marker reported as member");

endmodule

bind group_membership_table gmt_checker #(
    .SLOT_COUNT (SLOT_COUNT)
) u_gmt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast)
);
